>>> rtl/sle_pkg.sv
// Shared types and codes for the sorted list engine.
package sle_pkg;

    localparam int VALUE_W = 32;

    typedef enum logic [2:0] {
        REQ_INSERT     = 3'd0,
        REQ_DELETE     = 3'd1,
        REQ_SEARCH     = 3'd2,
        REQ_REMOVE_MIN = 3'd3,
        REQ_REMOVE_MAX = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // What every cell does with its entry on a committed request.
    typedef enum logic [1:0] {
        CM_HOLD      = 2'd0,
        CM_INSERT    = 2'd1,
        CM_CLOSE_GAP = 2'd2,
        CM_SHIFT_ALL = 2'd3
    } t_cell_mode;

    typedef struct packed {
        logic       en;
        t_cell_mode mode;
    } t_cell_ctrl;

endpackage

>>> rtl/sle_cell.sv
// One slot of the sorted chain: holds an entry and compares it with the operand.
module sle_cell
    import sle_pkg::*;
(
    input  logic                      i_clk,
    input  t_cell_ctrl                i_ctrl,
    input  logic signed [VALUE_W-1:0] i_operand,
    input  logic                      i_in_use,
    input  logic                      i_left_lt,
    input  logic signed [VALUE_W-1:0] i_left_val,
    input  logic signed [VALUE_W-1:0] i_right_val,
    output logic signed [VALUE_W-1:0] o_val,
    output logic                      o_lt,
    output logic                      o_eq
);

    logic signed [VALUE_W-1:0] r_val;
    logic signed [VALUE_W-1:0] n_val;

    assign o_val = r_val;
    assign o_lt  = i_in_use && (r_val < i_operand);
    assign o_eq  = i_in_use && (r_val == i_operand);

    always_comb begin
        n_val = r_val;
        case (i_ctrl.mode)
            CM_INSERT: begin
                // keep smaller entries, take the operand at the boundary, shift the rest up
                if (o_lt) begin
                    n_val = r_val;
                end else if (i_left_lt) begin
                    n_val = i_operand;
                end else begin
                    n_val = i_left_val;
                end
            end
            CM_CLOSE_GAP: begin
                if (!o_lt) begin
                    n_val = i_right_val;
                end
            end
            CM_SHIFT_ALL: n_val = i_right_val;
            default:      n_val = r_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            r_val <= n_val;
        end
    end

endmodule

>>> rtl/sorted_list_engine.sv
// Top level of the sorted list engine: request decode, cell chain and result register.
// A result appears in the output register in the cycle after its request is taken.
// Throughput: one request per cycle unless stalled; each cell compares its entry with
// broadcast operand and moves one slot in the same cycle, so no request waits on another.
// Reset (synchronous, active low) clears the entry count and the output valid flag;
// entry contents are not cleared, since only slots below the count are ever used.
module sorted_list_engine
    import sle_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] operand_value
    input  logic [2:0]  s_tuser,   // [2:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] removed_value, [36:32] entry_count,
                                   // [37] is_empty, [39:38] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

    // Chain wiring: each cell sees its neighbors' entries and the left one's compare.
    logic signed [VALUE_W-1:0] w_val [CAPACITY];
    logic [CAPACITY-1:0]       w_lt;
    logic [CAPACITY-1:0]       w_eq;
    logic [CAPACITY-1:0]       w_in_use;
    logic [CAPACITY-1:0]       w_last;

    logic [CW-1:0]             r_occ;
    logic [CW-1:0]             n_occ;
    logic                      r_m_valid;
    logic [VALUE_W-1:0]        r_removed;
    t_status                   r_status;
    logic [CW-1:0]             r_count;

    logic                      w_accept;
    logic signed [VALUE_W-1:0] w_operand;
    logic                      w_found;
    logic [VALUE_W-1:0]        w_top_val;
    t_cell_ctrl                w_ctrl;
    t_status                   w_status;
    logic [VALUE_W-1:0]        w_removed;
    logic [CW+4:0]             w_count_ext;

    // Take a new request whenever the output register is free or being drained.
    assign s_tready  = !r_m_valid || m_tready;
    assign w_accept  = s_tvalid && s_tready;
    assign w_operand = s_tdata;

    generate
        for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
            assign w_in_use[i] = CW'(i) < r_occ;
            if (i == CAPACITY - 1) begin : g_tail
                assign w_last[i] = w_in_use[i];
            end else begin : g_body
                assign w_last[i] = w_in_use[i] && !w_in_use[i+1];
            end

            sle_cell u_cell (
                .i_clk      (i_clk),
                .i_ctrl     (w_ctrl),
                .i_operand  (w_operand),
                .i_in_use   (w_in_use[i]),
                .i_left_lt  ((i == 0) ? 1'b1 : w_lt[(i == 0) ? 0 : i-1]),
                .i_left_val ((i == 0) ? w_operand : w_val[(i == 0) ? 0 : i-1]),
                .i_right_val((i == CAPACITY - 1) ? w_val[i]
                                                 : w_val[(i == CAPACITY - 1) ? i : i+1]),
                .o_val      (w_val[i]),
                .o_lt       (w_lt[i]),
                .o_eq       (w_eq[i])
            );
        end
    endgenerate

    assign w_found = |w_eq;

    // Pick the largest entry: only the last occupied cell drives the OR.
    always_comb begin
        w_top_val = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_top_val = w_top_val | (w_last[i] ? w_val[i] : '0);
        end
    end

    // Decode the request into a chain command, the new count and the result.
    always_comb begin
        w_ctrl.mode = CM_HOLD;
        n_occ       = r_occ;
        w_status    = ST_MISS;
        w_removed   = '0;
        unique case (s_tuser)
            REQ_INSERT: begin
                if (r_occ == FULL_COUNT) begin
                    w_status = ST_FULL;
                end else begin
                    w_ctrl.mode = CM_INSERT;
                    n_occ       = r_occ + CW'(1);
                    w_status    = ST_DONE;
                end
            end
            REQ_DELETE: begin
                // the first equal entry sits at the first slot not below the operand
                if (w_found) begin
                    w_ctrl.mode = CM_CLOSE_GAP;
                    n_occ       = r_occ - CW'(1);
                    w_status    = ST_DONE;
                end
            end
            REQ_SEARCH: begin
                if (w_found) begin
                    w_status = ST_DONE;
                end
            end
            REQ_REMOVE_MIN: begin
                if (r_occ != '0) begin
                    w_ctrl.mode = CM_SHIFT_ALL;
                    n_occ       = r_occ - CW'(1);
                    w_status    = ST_DONE;
                    w_removed   = w_val[0];
                end
            end
            REQ_REMOVE_MAX: begin
                // drop the top slot by shrinking the count; entries stay put
                if (r_occ != '0) begin
                    n_occ     = r_occ - CW'(1);
                    w_status  = ST_DONE;
                    w_removed = w_top_val;
                end
            end
            default: begin
                w_status = ST_MISS;
            end
        endcase
        w_ctrl.en = w_accept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_occ     <= n_occ;
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Result payload: load with each accepted request, hold while stalled.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_removed <= w_removed;
            r_status  <= w_status;
            r_count   <= n_occ;
        end
    end

    assign w_count_ext = {5'b0, r_count};

    assign m_tvalid = r_m_valid;
    assign m_tdata  = {2'b00, (r_count == '0), w_count_ext[4:0], r_removed};
    assign m_tuser  = r_status;

endmodule
